// File: hdl/lsc_pkg.sv
package lsc_pkg;

  // Field and datapath widths
  localparam int DataW   = 32;
  localparam int PairW   = 2 * DataW;
  localparam int TripW   = 3 * DataW;
  localparam int SumW    = TripW + 2;
  localparam int MagW    = TripW;
  localparam int FracW   = 16;
  localparam int NumW    = MagW + FracW;
  localparam int QuoW    = DataW + 1;
  localparam int CmpW    = MagW + QuoW;
  localparam int ThrW    = 16;
  localparam int ThrSh   = 32;

  // Determinant layout: main matrix plus one per replaced column
  localparam int NumDim  = 3;
  localparam int NumMat  = NumDim + 1;
  localparam int NumTerm = 6;

  // Pipeline depth: seven front stages, one stage per quotient bit, output stage
  localparam int NumFront = 7;
  localparam int NumStg   = NumFront + QuoW + 1;

  localparam logic [ThrW-1:0] ThrReset = ThrW'(1);

  // Sarrus terms: column and row of each factor; terms three to five are subtracted
  localparam int FacCol [NumTerm][3] = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1},
                                         '{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}};
  localparam int FacRow [NumTerm][3] = '{'{0, 1, 2}, '{0, 1, 2}, '{0, 1, 2},
                                         '{2, 1, 0}, '{2, 1, 0}, '{2, 1, 0}};

endpackage

// File: hdl/lsc_in_if.sv
interface lsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] col0_row0;
  logic signed [31:0] col0_row1;
  logic signed [31:0] col0_row2;
  logic signed [31:0] col1_row0;
  logic signed [31:0] col1_row1;
  logic signed [31:0] col1_row2;
  logic signed [31:0] col2_row0;
  logic signed [31:0] col2_row1;
  logic signed [31:0] col2_row2;
  logic signed [31:0] rhs_x;
  logic signed [31:0] rhs_y;
  logic signed [31:0] rhs_z;

  modport source (output valid, input ready, output col0_row0, col0_row1, col0_row2,
                  col1_row0, col1_row1, col1_row2, col2_row0, col2_row1, col2_row2,
                  rhs_x, rhs_y, rhs_z);
  modport sink (input valid, output ready, input col0_row0, col0_row1, col0_row2,
                col1_row0, col1_row1, col1_row2, col2_row0, col2_row1, col2_row2,
                rhs_x, rhs_y, rhs_z);
endinterface

// File: hdl/lsc_out_if.sv
interface lsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sol_x;
  logic signed [31:0] sol_y;
  logic signed [31:0] sol_z;
  logic               singular;
  logic               saturated;

  modport source (output valid, input ready, output sol_x, sol_y, sol_z, singular,
                  saturated);
  modport sink (input valid, output ready, input sol_x, sol_y, sol_z, singular,
                saturated);
endinterface

// File: hdl/linear_solve_3x3_cramer_unit.sv
// Pipeline from input transfer to result valid: 7 determinant/setup stages,
//   33 restoring-division stages of one quotient bit each, and an output stage.
// Throughput: one system per cycle; the whole pipeline stalls together while a
//   result waits at the output register.
// Reset: rst_ni clears all valid bits and sets the threshold register to 1.
module linear_solve_3x3_cramer_unit import lsc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  lsc_in_if.sink          in_i,
  lsc_out_if.source       out_o
);

  logic [NumStg-1:0] vld_q;
  logic              adv;
  logic [ThrW-1:0]   thr_q;

  logic signed [DataW-1:0] ent [3][3];
  logic signed [DataW-1:0] rhs [3];
  logic signed [DataW-1:0] fac [NumMat][NumTerm][3];

  logic signed [PairW-1:0] pab_q [NumMat][NumTerm];
  logic signed [DataW-1:0] cf_q  [NumMat][NumTerm];
  logic signed [PairW:0]   plo_q [NumMat][NumTerm];
  logic signed [PairW-1:0] phi_q [NumMat][NumTerm];
  logic signed [TripW-1:0] tp_q  [NumMat][NumTerm];
  logic signed [SumW-1:0]  sa_q [NumMat];
  logic signed [SumW-1:0]  sb_q [NumMat];
  logic signed [SumW-1:0]  sc_q [NumMat];
  logic signed [SumW-1:0]  det_q [NumMat];

  logic [SumW-1:0] dabs [NumMat];
  logic [MagW-1:0] s6_dmag_q;
  logic            s6_sing_q;
  logic            s6_neg_q [NumDim];
  logic [NumW-1:0] s6_num_q [NumDim];

  // Division pipe: index 0 is the setup stage, index j holds bits down to QuoW-j
  logic [MagW-1:0] dv_dmag_q [QuoW];
  logic [NumW-1:0] dv_rem_q  [QuoW][NumDim];
  logic [QuoW-1:0] dv_quo_q  [QuoW+1][NumDim];
  logic            dv_ovf_q  [QuoW+1][NumDim];
  logic            dv_neg_q  [QuoW+1][NumDim];
  logic            dv_sing_q [QuoW+1];

  logic [CmpW-1:0] dv_sh [QuoW+1][NumDim];
  logic            dv_ge [QuoW+1][NumDim];

  logic signed [DataW-1:0] sol_d [NumDim];
  logic signed [DataW-1:0] sol_q [NumDim];
  logic            sat_d, sat_q, sing_q;

  // Advance the whole pipe unless a result is held at the output
  assign adv        = !vld_q[NumStg-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], in_i.valid};
    end
  end

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Gather entries by column and row, then the factors of every term
  always_comb begin
    ent[0][0] = in_i.col0_row0;
    ent[0][1] = in_i.col0_row1;
    ent[0][2] = in_i.col0_row2;
    ent[1][0] = in_i.col1_row0;
    ent[1][1] = in_i.col1_row1;
    ent[1][2] = in_i.col1_row2;
    ent[2][0] = in_i.col2_row0;
    ent[2][1] = in_i.col2_row1;
    ent[2][2] = in_i.col2_row2;
    rhs[0]    = in_i.rhs_x;
    rhs[1]    = in_i.rhs_y;
    rhs[2]    = in_i.rhs_z;
    for (int k = 0; k < NumMat; k++) begin
      for (int t = 0; t < NumTerm; t++) begin
        for (int f = 0; f < 3; f++) begin
          if (k != 0 && FacCol[t][f] == k - 1) begin
            fac[k][t][f] = rhs[FacRow[t][f]];
          end else begin
            fac[k][t][f] = ent[FacCol[t][f]][FacRow[t][f]];
          end
        end
      end
    end
  end

  // Stages 1-5: triple products and their sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumMat; k++) begin
        for (int t = 0; t < NumTerm; t++) begin
          pab_q[k][t] <= PairW'(fac[k][t][0]) * PairW'(fac[k][t][1]);
          cf_q[k][t]  <= fac[k][t][2];
          plo_q[k][t] <= (PairW+1)'($signed({1'b0, pab_q[k][t][DataW-1:0]}))
                         * (PairW+1)'(cf_q[k][t]);
          phi_q[k][t] <= PairW'($signed(pab_q[k][t][PairW-1:DataW])) * PairW'(cf_q[k][t]);
          tp_q[k][t]  <= (TripW'(phi_q[k][t]) <<< DataW) + TripW'(plo_q[k][t]);
        end
        sa_q[k]  <= SumW'(tp_q[k][0]) + SumW'(tp_q[k][1]);
        sb_q[k]  <= SumW'(tp_q[k][2]) - SumW'(tp_q[k][3]);
        sc_q[k]  <= SumW'(tp_q[k][4]) + SumW'(tp_q[k][5]);
        det_q[k] <= sa_q[k] + sb_q[k] - sc_q[k];
      end
    end
  end

  // Stage 6: magnitudes, signs, singular test
  always_comb begin
    for (int k = 0; k < NumMat; k++) begin
      dabs[k] = det_q[k][SumW-1] ? SumW'(-det_q[k]) : SumW'(det_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_dmag_q <= dabs[0][MagW-1:0];
      s6_sing_q <= dabs[0] <= SumW'({thr_q, ThrSh'(0)});
      for (int i = 0; i < NumDim; i++) begin
        s6_neg_q[i] <= det_q[i+1][SumW-1] ^ det_q[0][SumW-1];
        s6_num_q[i] <= {dabs[i+1][MagW-1:0], FracW'(0)};
      end
    end
  end

  // Division steps: compare the remainder against the shifted divisor
  always_comb begin
    for (int i = 0; i < NumDim; i++) begin
      dv_sh[0][i] = CmpW'(s6_dmag_q) << QuoW;
      dv_ge[0][i] = CmpW'(s6_num_q[i]) >= dv_sh[0][i];
    end
    for (int j = 1; j <= QuoW; j++) begin
      for (int i = 0; i < NumDim; i++) begin
        dv_sh[j][i] = CmpW'(dv_dmag_q[j-1]) << (QuoW - j);
        dv_ge[j][i] = CmpW'(dv_rem_q[j-1][i]) >= dv_sh[j][i];
      end
    end
  end

  // Stage 7 sets up the quotient; each later stage resolves one bit
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_dmag_q[0] <= s6_dmag_q;
      dv_sing_q[0] <= s6_sing_q;
      for (int i = 0; i < NumDim; i++) begin
        dv_rem_q[0][i] <= s6_num_q[i];
        dv_quo_q[0][i] <= '0;
        dv_ovf_q[0][i] <= dv_ge[0][i];
        dv_neg_q[0][i] <= s6_neg_q[i];
      end
      for (int j = 1; j <= QuoW; j++) begin
        dv_sing_q[j] <= dv_sing_q[j-1];
        if (j < QuoW) begin
          dv_dmag_q[j] <= dv_dmag_q[j-1];
        end
        for (int i = 0; i < NumDim; i++) begin
          if (j < QuoW) begin
            dv_rem_q[j][i] <= dv_ge[j][i] ? dv_rem_q[j-1][i] - dv_sh[j][i][NumW-1:0]
                                          : dv_rem_q[j-1][i];
          end
          dv_quo_q[j][i] <= dv_quo_q[j-1][i] | (QuoW'(dv_ge[j][i]) << (QuoW - j));
          dv_ovf_q[j][i] <= dv_ovf_q[j-1][i];
          dv_neg_q[j][i] <= dv_neg_q[j-1][i];
        end
      end
    end
  end

  // Sign, clamp and singular override
  always_comb begin
    logic            neg;
    logic [QuoW-1:0] q;
    logic [QuoW-1:0] lim;
    logic [QuoW-1:0] mag;
    logic            over;
    sat_d = 1'b0;
    for (int i = 0; i < NumDim; i++) begin
      q    = dv_quo_q[QuoW][i];
      neg  = dv_neg_q[QuoW][i] && (q != '0);
      lim  = neg ? QuoW'(1) << (DataW - 1) : (QuoW'(1) << (DataW - 1)) - QuoW'(1);
      over = dv_ovf_q[QuoW][i] || (q > lim);
      mag  = over ? lim : q;
      sat_d = sat_d | over;
      sol_d[i] = neg ? -$signed(mag[DataW-1:0]) : $signed(mag[DataW-1:0]);
      if (dv_sing_q[QuoW]) begin
        sol_d[i] = '0;
      end
    end
    if (dv_sing_q[QuoW]) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sol_q  <= sol_d;
      sat_q  <= sat_d;
      sing_q <= dv_sing_q[QuoW];
    end
  end

  assign out_o.valid     = vld_q[NumStg-1];
  assign out_o.sol_x     = sol_q[0];
  assign out_o.sol_y     = sol_q[1];
  assign out_o.sol_z     = sol_q[2];
  assign out_o.singular  = sing_q;
  assign out_o.saturated = sat_q;

endmodule

// File: hdl/lsc_checker.sv
module lsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] sol_x_i,
  input logic [31:0] sol_y_i,
  input logic [31:0] sol_z_i,
  input logic        singular_i,
  input logic        saturated_i
);

  // Input side stalls only while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output backpressure");

  // Singular systems give a zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && singular_i) |-> (sol_x_i == '0 && sol_y_i == '0 && sol_z_i == '0))
    else $error("singular result with nonzero solution");

  // Singular and saturated never both set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(singular_i && saturated_i))
    else $error("singular result flagged saturated");

  // Held result stays put until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sol_x_i)
      && $stable(sol_y_i) && $stable(sol_z_i) && $stable(singular_i)
      && $stable(saturated_i)))
    else $error("stalled result changed");

endmodule

bind linear_solve_3x3_cramer_unit lsc_checker u_lsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sol_x_i     (out_o.sol_x),
  .sol_y_i     (out_o.sol_y),
  .sol_z_i     (out_o.sol_z),
  .singular_i  (out_o.singular),
  .saturated_i (out_o.saturated)
);
